### src/fir_pkg.sv
package fir_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int INDEX_W   = 6;
   localparam int PROD_W    = 32;
   localparam int ACC_W     = 40;
   localparam int FRAC_BITS = 15;
   localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);

   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   typedef struct packed {
      logic load_coef;
      logic push_sample;
      logic issue;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last_issue;
      logic acc_done;
   } sts_type;

endpackage

### src/fir_datapath.sv
module fir_datapath #(
   parameter int NUM_TAPS = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fir_pkg::cmd_type                    cmd,
   output fir_pkg::sts_type                    sts,
   input  logic signed [fir_pkg::SAMPLE_W-1:0] sample,
   input  logic        [fir_pkg::INDEX_W-1:0]  coef_index,
   input  logic signed [fir_pkg::SAMPLE_W-1:0] coef_value,
   output logic signed [fir_pkg::SAMPLE_W-1:0] filtered,
   output logic                                saturated
);

   localparam int AW = $clog2(NUM_TAPS);
   localparam int CW = $clog2(NUM_TAPS + 1);
   localparam int IW = ((fir_pkg::INDEX_W > AW) ? fir_pkg::INDEX_W : AW) + 1;
   localparam int YW = fir_pkg::ACC_W - fir_pkg::FRAC_BITS;
   localparam int SW = fir_pkg::SAMPLE_W;
   localparam int EXT_W = fir_pkg::ACC_W - fir_pkg::PROD_W;

   logic signed [SW-1:0] coef_mem  [NUM_TAPS];
   logic signed [SW-1:0] delay_mem [NUM_TAPS];

   logic [AW-1:0] wptr_ff, wptr_in;
   logic [AW-1:0] rptr_ff, rptr_in;
   logic [AW-1:0] tap_ff, tap_in;
   logic [CW-1:0] fill_ff, fill_in;

   logic signed [SW-1:0] coef_rd_ff, delay_rd_ff;
   logic                 s1_go_ff, s1_last_ff, s1_live_ff;
   logic signed [fir_pkg::PROD_W-1:0] prod_ff, prod_in, prod_raw;
   logic                 s2_go_ff, s2_last_ff;
   logic signed [fir_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic                 done_ff;

   logic signed [SW-1:0] filtered_ff, filtered_in;
   logic                 sat_ff, sat_in;

   logic [IW-1:0]        idx_wide;
   logic                 idx_ok;
   logic signed [fir_pkg::ACC_W-1:0] biased;
   logic signed [YW-1:0] y_full;

   assign idx_wide = IW'(coef_index);
   assign idx_ok   = idx_wide < IW'(NUM_TAPS);

   // memories: coefficient table and circular delay line
   always_ff @(posedge clock) begin
      if (cmd.load_coef && idx_ok) begin
         coef_mem[idx_wide[AW-1:0]] <= coef_value;
      end
      if (cmd.push_sample) begin
         delay_mem[wptr_ff] <= sample;
      end
      coef_rd_ff  <= coef_mem[tap_ff];
      delay_rd_ff <= delay_mem[rptr_ff];
   end

   always_comb begin
      wptr_in = wptr_ff;
      fill_in = fill_ff;
      rptr_in = rptr_ff;
      tap_in  = tap_ff;
      if (cmd.push_sample) begin
         wptr_in = (wptr_ff == AW'(NUM_TAPS - 1)) ? '0 : wptr_ff + 1'b1;
         fill_in = (fill_ff == CW'(NUM_TAPS)) ? fill_ff : fill_ff + 1'b1;
         rptr_in = wptr_ff;   // newest sample is tap 0
         tap_in  = '0;
      end else if (cmd.issue) begin
         rptr_in = (rptr_ff == '0) ? AW'(NUM_TAPS - 1) : rptr_ff - 1'b1;
         tap_in  = tap_ff + 1'b1;
      end
   end

   // product kept in its own signed signal so the operands stay signed
   assign prod_raw = coef_rd_ff * delay_rd_ff;
   assign prod_in  = s1_live_ff ? prod_raw : '0;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.push_sample) begin
         acc_in = '0;
      end else if (s2_go_ff) begin
         acc_in = acc_ff + {{EXT_W{prod_ff[fir_pkg::PROD_W-1]}}, prod_ff};
      end
   end

   // round half up, floor shift, clip to 16 bits
   assign biased = acc_ff + fir_pkg::ACC_W'(fir_pkg::ROUND_BIAS);
   assign y_full = biased[fir_pkg::ACC_W-1:fir_pkg::FRAC_BITS];

   always_comb begin
      filtered_in = filtered_ff;
      sat_in      = sat_ff;
      if (cmd.emit) begin
         if (y_full[YW-1:SW-1] == '0 || y_full[YW-1:SW-1] == '1) begin
            filtered_in = y_full[SW-1:0];
            sat_in      = 1'b0;
         end else begin
            filtered_in = y_full[YW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            sat_in      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff    <= '0;
         fill_ff    <= '0;
         rptr_ff    <= '0;
         tap_ff     <= '0;
         s1_go_ff   <= 1'b0;
         s2_go_ff   <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         wptr_ff    <= wptr_in;
         fill_ff    <= fill_in;
         rptr_ff    <= rptr_in;
         tap_ff     <= tap_in;
         s1_go_ff   <= cmd.issue;
         s2_go_ff   <= s1_go_ff;
         done_ff    <= s2_go_ff && s2_last_ff;
      end
      s1_last_ff  <= tap_ff == AW'(NUM_TAPS - 1);
      s1_live_ff  <= CW'(tap_ff) < fill_ff;   // taps older than the fill read as zero
      prod_ff     <= prod_in;
      s2_last_ff  <= s1_last_ff;
      acc_ff      <= acc_in;
      filtered_ff <= filtered_in;
      sat_ff      <= sat_in;
   end

   assign sts.last_issue = tap_ff == AW'(NUM_TAPS - 1);
   assign sts.acc_done   = done_ff;
   assign filtered       = filtered_ff;
   assign saturated      = sat_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(NUM_TAPS))
      else $error("delay line fill count beyond tap count");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      wptr_ff <= AW'(NUM_TAPS - 1) && rptr_ff <= AW'(NUM_TAPS - 1))
      else $error("delay line pointer out of range");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(s2_go_ff) && $past(s2_last_ff))
      else $error("accumulate finished without last tap");
`endif

endmodule

### src/fir_ctrl.sv
module fir_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_command,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fir_pkg::cmd_type cmd,
   input  fir_pkg::sts_type sts
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in          = state_ff;
      cmd.load_coef     = 1'b0;
      cmd.push_sample   = 1'b0;
      cmd.issue         = 1'b0;
      cmd.emit          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == fir_pkg::CMD_LOAD) begin
                  cmd.load_coef = 1'b1;
               end else begin
                  cmd.push_sample = 1'b1;
                  state_in        = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (sts.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (sts.acc_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      sts.acc_done |-> state_ff == ST_DRAIN)
      else $error("accumulator finished outside drain");

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result beat raised outside finish");

   a_run_to_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN && sts.last_issue |=> state_ff == ST_DRAIN)
      else $error("tap sweep did not end in drain");
`endif

endmodule

### src/fir_filter.sv
// Direct-form FIR, one multiply-accumulate per tap through a shared MAC.
// Sample beat: after accept the taps are swept over the coefficient and
// delay-line memories, the MAC pipeline drains, and the result goes to the
// output register once any earlier result is taken; then the next beat is taken.
// Coefficient load beats are taken one per cycle while idle and give no result.
// Synchronous reset empties the delay line (reads as zero) and drops any result.
module fir_filter #(
   parameter int NUM_TAPS = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic signed [fir_pkg::SAMPLE_W-1:0] req_sample,
   input  logic        [fir_pkg::INDEX_W-1:0]  req_coef_index,
   input  logic signed [fir_pkg::SAMPLE_W-1:0] req_coef_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [fir_pkg::SAMPLE_W-1:0] rsp_filtered,
   output logic                                rsp_saturated
);

   fir_pkg::cmd_type cmd;
   fir_pkg::sts_type sts;

   fir_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd),
      .sts         (sts)
   );

   fir_datapath #(
      .NUM_TAPS (NUM_TAPS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .sample     (req_sample),
      .coef_index (req_coef_index),
      .coef_value (req_coef_value),
      .filtered   (rsp_filtered),
      .saturated  (rsp_saturated)
   );

endmodule
